FILE: src/rht_pkg.sv
// Shared types and constants for the header-field tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none
package rht_pkg;

    localparam int MAX_DEPTH_DEF = 15;
    localparam int MAX_RES       = 5;   // most token bytes one input byte can cause
    localparam int CNT_W         = $clog2(MAX_RES + 1);
    localparam int IDX_W         = $clog2(MAX_RES);

    localparam logic [63:0] SPECIALS_LOW_RST  = 64'd6629389928134344704;
    localparam logic [63:0] SPECIALS_HIGH_RST = 64'd939524097;

    // configuration register indexes
    localparam logic [1:0] CFG_SPECIALS_LOW  = 2'd0;
    localparam logic [1:0] CFG_SPECIALS_HIGH = 2'd1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CLS_C     = 8'h43;
    localparam logic [7:0] CLS_D     = 8'h44;
    localparam logic [7:0] CLS_Q     = 8'h51;
    localparam logic [7:0] CLS_S     = 8'h53;
    localparam logic [7:0] CLS_W     = 8'h57;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_COMMENT,
        MODE_LITERAL,
        MODE_QUOTE
    } lex_mode_t;

    // token bytes caused by one input beat
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    last;
        logic                    perr;
    } rht_res_t;

endpackage
`default_nettype wire

FILE: src/rfc822_header_tokenizer.sv
// Top level of the header-field tokenizer: configuration registers, lexer, result buffer.
// Depends on rht_pkg, rht_lexer and rht_serializer.
//
// Takes one header-field byte per beat (s_tlast on the field's last byte) and sends
// the token stream one byte per beat: a zero byte, the token body, then a class
// letter C, D, Q, S or W. An input byte is lexed in the cycle it is accepted and
// its token bytes (zero to five) land in a result buffer; a byte that causes no
// token bytes does not hold the input. A byte that causes n token bytes occupies the
// output until its n bytes have left one per beat, and the next input byte is accepted
// in the cycle its last one leaves, so the single-byte output port sets the input rate.
// The user must write the specials tables through the cfg channel (index 0: bytes
// 0x00-0x3F, index 1: bytes 0x40-0x7F) while the block is idle; it does not enforce this.
`default_nettype none
module rfc822_header_tokenizer
    import rht_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
    input  wire logic        s_tlast,    // field_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] token_byte
    output logic             m_tlast,    // stream_end
    output logic [1:0]       m_tuser,    // [0] run_end, [1] parse_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] specials_low_reg;
    logic [63:0] specials_high_reg;
    logic        in_fire;
    rht_res_t    res;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            specials_low_reg  <= SPECIALS_LOW_RST;
            specials_high_reg <= SPECIALS_HIGH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SPECIALS_LOW:  specials_low_reg  <= cfg_data;
                CFG_SPECIALS_HIGH: specials_high_reg <= cfg_data;
                default: begin
                    // unmapped index: ignore
                end
            endcase
        end
    end

    rht_lexer #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .in_byte      (s_tdata),
        .field_end    (s_tlast),
        .specials_low (specials_low_reg),
        .specials_high(specials_high_reg),
        .res          (res)
    );

    rht_serializer u_serializer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .res     (res),
        .in_ready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule
`default_nettype wire

FILE: src/rht_lexer.sv
// Lexer state and the per-byte decode that yields up to MAX_RES token bytes.
// Depends on rht_pkg.
`default_nettype none
module rht_lexer
    import rht_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_fire,
    input  wire logic [7:0]  in_byte,
    input  wire logic        field_end,
    input  wire logic [63:0] specials_low,
    input  wire logic [63:0] specials_high,
    output rht_res_t         res
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    lex_mode_t            mode_reg, mode_next, mid_mode;
    logic [DEPTH_W-1:0]   depth_reg, depth_next, mid_depth;
    logic                 esc_reg, esc_next, mid_esc;

    logic                 is_spec, is_blank, bs_plain;
    logic [7:0]           bts;
    logic [2:0][7:0]      idl_bytes;
    logic [CNT_W-1:0]     idl_cnt;
    lex_mode_t            idl_mode;
    logic                 idl_esc;
    logic [DEPTH_W-1:0]   idl_depth;

    logic [MAX_RES-1:0][7:0] main_bytes;
    logic [CNT_W-1:0]        main_cnt;
    logic [1:0][7:0]         tail_bytes;
    logic [CNT_W-1:0]        tail_cnt;
    logic                    tail_perr;

    // byte classes and the handling of a byte met between tokens
    always_comb begin
        if (!in_byte[7] && !in_byte[6]) begin
            is_spec = specials_low[in_byte[5:0]];
        end else if (!in_byte[7]) begin
            is_spec = specials_high[in_byte[5:0]];
        end else begin
            is_spec = 1'b0;
        end
        is_blank = in_byte inside {CH_SPACE, CH_CR, CH_LF, CH_TAB, CH_NUL};
        bs_plain = (in_byte == CH_BSLASH) && !field_end;
        bts      = (in_byte == CH_LF || in_byte == CH_TAB) ? CH_SPACE : in_byte;

        idl_bytes = '0;
        idl_mode  = MODE_IDLE;
        idl_esc   = 1'b0;
        idl_depth = depth_reg;
        if (in_byte == CH_LPAREN) begin
            idl_cnt   = CNT_W'(1);
            idl_mode  = MODE_COMMENT;
            idl_depth = DEPTH_ONE;
        end else if (in_byte == CH_LBRACK) begin
            idl_bytes[1] = CH_LBRACK;
            idl_cnt      = CNT_W'(2);
            idl_mode     = MODE_LITERAL;
        end else if (in_byte == CH_DQUOTE) begin
            idl_cnt  = CNT_W'(1);
            idl_mode = MODE_QUOTE;
        end else if (is_spec) begin
            idl_bytes[1] = in_byte;
            idl_bytes[2] = CLS_S;
            idl_cnt      = CNT_W'(3);
        end else if (is_blank) begin
            idl_bytes[1] = CH_SPACE;
            idl_bytes[2] = CLS_S;
            idl_cnt      = CNT_W'(3);
        end else begin
            idl_mode = MODE_WORD;
            if (bs_plain) begin
                idl_cnt = CNT_W'(1);
                idl_esc = 1'b1;
            end else begin
                idl_bytes[1] = in_byte;
                idl_cnt      = CNT_W'(2);
            end
        end
    end

    // next state
    always_comb begin
        mid_mode  = mode_reg;
        mid_depth = depth_reg;
        mid_esc   = esc_reg;
        case (mode_reg)
            MODE_WORD: begin
                if (esc_reg) begin
                    mid_esc = 1'b0;
                end else if (is_spec) begin
                    mid_mode  = idl_mode;
                    mid_depth = idl_depth;
                    mid_esc   = idl_esc;
                end else if (is_blank) begin
                    mid_mode = MODE_IDLE;
                end else if (bs_plain) begin
                    mid_esc = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (esc_reg) begin
                    mid_esc = 1'b0;
                end else if (in_byte == CH_RPAREN) begin
                    if (depth_reg <= DEPTH_ONE) begin
                        mid_depth = '0;
                        mid_mode  = MODE_IDLE;
                    end else begin
                        mid_depth = depth_reg - DEPTH_ONE;
                    end
                end else if (bs_plain) begin
                    mid_esc = 1'b1;
                end else if (in_byte == CH_LPAREN && depth_reg < DEPTH_MAX) begin
                    mid_depth = depth_reg + DEPTH_ONE;
                end
            end
            MODE_LITERAL, MODE_QUOTE: begin
                if (esc_reg) begin
                    mid_esc = 1'b0;
                end else if ((mode_reg == MODE_LITERAL && in_byte == CH_RBRACK) ||
                             (mode_reg == MODE_QUOTE && in_byte == CH_DQUOTE)) begin
                    mid_mode = MODE_IDLE;
                end else if (bs_plain) begin
                    mid_esc = 1'b1;
                end
            end
            default: begin
                mid_mode  = idl_mode;
                mid_depth = idl_depth;
                mid_esc   = idl_esc;
            end
        endcase

        // end of field returns everything to reset
        if (field_end) begin
            mode_next  = MODE_IDLE;
            depth_next = '0;
            esc_next   = 1'b0;
        end else begin
            mode_next  = mid_mode;
            depth_next = mid_depth;
            esc_next   = mid_esc;
        end
    end

    // token bytes
    always_comb begin
        main_bytes = '0;
        main_cnt   = '0;
        case (mode_reg)
            MODE_WORD: begin
                if (esc_reg) begin
                    main_bytes[0] = (in_byte == CH_NUL) ? CH_SPACE : in_byte;
                    main_cnt      = CNT_W'(1);
                end else if (is_spec) begin
                    main_bytes[0] = CLS_W;
                    main_bytes[1] = idl_bytes[0];
                    main_bytes[2] = idl_bytes[1];
                    main_bytes[3] = idl_bytes[2];
                    main_cnt      = idl_cnt + CNT_W'(1);
                end else if (is_blank) begin
                    main_bytes[0] = CLS_W;
                    main_cnt      = CNT_W'(1);
                end else if (!bs_plain) begin
                    main_bytes[0] = in_byte;
                    main_cnt      = CNT_W'(1);
                end
            end
            MODE_COMMENT: begin
                if (esc_reg) begin
                    main_bytes[0] = bts;
                    main_cnt      = CNT_W'(1);
                end else if (in_byte == CH_RPAREN) begin
                    main_bytes[0] = (depth_reg <= DEPTH_ONE) ? CLS_C : CH_RPAREN;
                    main_cnt      = CNT_W'(1);
                end else if (!bs_plain) begin
                    main_bytes[0] = bts;
                    main_cnt      = CNT_W'(1);
                end
            end
            MODE_LITERAL, MODE_QUOTE: begin
                if (esc_reg) begin
                    main_bytes[0] = bts;
                    main_cnt      = CNT_W'(1);
                end else if (mode_reg == MODE_LITERAL && in_byte == CH_RBRACK) begin
                    main_bytes[0] = CH_RBRACK;
                    main_bytes[1] = CLS_D;
                    main_cnt      = CNT_W'(2);
                end else if (mode_reg == MODE_QUOTE && in_byte == CH_DQUOTE) begin
                    main_bytes[0] = CLS_Q;
                    main_cnt      = CNT_W'(1);
                end else if (!bs_plain) begin
                    main_bytes[0] = bts;
                    main_cnt      = CNT_W'(1);
                end
            end
            default: begin
                main_bytes[0] = idl_bytes[0];
                main_bytes[1] = idl_bytes[1];
                main_bytes[2] = idl_bytes[2];
                main_cnt      = idl_cnt;
            end
        endcase

        // close whatever token is still open at the end of the field
        tail_bytes = '0;
        tail_cnt   = '0;
        tail_perr  = 1'b0;
        if (field_end) begin
            case (mid_mode)
                MODE_WORD: begin
                    tail_bytes[0] = CLS_W;
                    tail_cnt      = CNT_W'(1);
                end
                MODE_COMMENT: begin
                    tail_bytes[0] = CLS_C;
                    tail_cnt      = CNT_W'(1);
                end
                MODE_LITERAL: begin
                    tail_bytes[0] = CH_RBRACK;
                    tail_bytes[1] = CLS_D;
                    tail_cnt      = CNT_W'(2);
                end
                MODE_QUOTE: begin
                    tail_bytes[0] = CLS_Q;
                    tail_cnt      = CNT_W'(1);
                    tail_perr     = 1'b1;
                end
                default: begin
                    tail_cnt = '0;
                end
            endcase
        end

        for (int i = 0; i < MAX_RES; i++) begin
            if (CNT_W'(i) < main_cnt) begin
                res.bytes[i] = main_bytes[i];
            end else if (CNT_W'(i) - main_cnt == '0) begin
                res.bytes[i] = tail_bytes[0];
            end else begin
                res.bytes[i] = tail_bytes[1];
            end
        end
        res.count = main_cnt + tail_cnt;
        res.last  = field_end;
        res.perr  = tail_perr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            depth_reg <= '0;
            esc_reg   <= 1'b0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            esc_reg   <= esc_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/rht_serializer.sv
// Result buffer: holds the token bytes of one input beat and sends them one per beat.
// Depends on rht_pkg.
`default_nettype none
module rht_serializer
    import rht_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire rht_res_t   res,
    output logic            in_ready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic [1:0]      m_tuser
);

    logic [MAX_RES-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        ptr_reg;
    logic                    valid_reg;
    logic                    last_reg;
    logic                    perr_reg;
    logic                    fin;

    assign fin      = (ptr_reg == IDX_W'(cnt_reg - CNT_W'(1)));
    assign in_ready = !valid_reg || (m_tready && fin);

    assign m_tvalid   = valid_reg;
    assign m_tdata    = bytes_reg[ptr_reg];
    assign m_tlast    = fin && last_reg;
    assign m_tuser[0] = fin;
    assign m_tuser[1] = fin && last_reg && perr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
        end else if (in_fire && res.count != '0) begin
            valid_reg <= 1'b1;
            ptr_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            // drop the buffer after its final byte, else advance
            if (fin) begin
                valid_reg <= 1'b0;
            end else begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && res.count != '0) begin
            bytes_reg <= res.bytes;
            cnt_reg   <= res.count;
            last_reg  <= res.last;
            perr_reg  <= res.perr;
        end
    end

endmodule
`default_nettype wire
